// File: rtl/svs_pkg.sv
package svs_pkg;

    localparam int SVS_VALUE_DEPTH = 256;
    localparam int SVS_FRAME_DEPTH = 64;
    localparam int SVS_VAR_DEPTH   = 256;
    localparam int SVS_VALUE_WIDTH = 64;

    localparam logic [3:0] KIND_PUSH_FRAME    = 4'd0;
    localparam logic [3:0] KIND_POP_FRAME     = 4'd1;
    localparam logic [3:0] KIND_PUSH_VALUE    = 4'd2;
    localparam logic [3:0] KIND_POP_VALUE     = 4'd3;
    localparam logic [3:0] KIND_READ_TOP      = 4'd4;
    localparam logic [3:0] KIND_PUSH_VARIABLE = 4'd5;
    localparam logic [3:0] KIND_FIND          = 4'd6;
    localparam logic [3:0] KIND_FIND_IN_SCOPE = 4'd7;
    localparam logic [3:0] KIND_WRITE_SLOT    = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value_in;
        logic [31:0] var_id;
        logic [7:0]  slot_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [63:0] value_out;
        logic [6:0]  frame_depth_out;
        logic [8:0]  stack_size_out;
        logic [8:0]  peak_size;
    } rsp_t;

endpackage

// File: rtl/svs_ram.sv
module svs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/scoped_variable_stack_unit.sv
// Scoped variable stack. A command is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with done high, and it
// cannot be held off. busy stays high through the done cycle, so the next
// transfer comes in the cycle after done at the earliest. Each command goes
// from a read state to an execute state and ends in the done state:
// push_frame, pop_frame, unused kinds and any command that reports full,
// empty or not found without a scan go from execute straight to done; value
// pushes, pops, reads and slot writes first pass the value RAM states S_VAL
// and S_VAL2. find and find_in_scope scan the variable table newest to oldest
// through one shared compare, entry by entry from a registered table RAM
// (address, then compare); a hit then passes S_VAL and S_VAL2 as well.
// No clearing pass is needed after reset.
module scoped_variable_stack_unit #(
    parameter int VALUE_DEPTH = svs_pkg::SVS_VALUE_DEPTH,
    parameter int FRAME_DEPTH = svs_pkg::SVS_FRAME_DEPTH,
    parameter int VAR_DEPTH   = svs_pkg::SVS_VAR_DEPTH,
    parameter int VALUE_WIDTH = svs_pkg::SVS_VALUE_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  svs_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output svs_pkg::rsp_t rsp
);
    import svs_pkg::*;

    localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int EAW = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int ECW = $clog2(VAR_DEPTH + 1);
    localparam int ENW = VAW + FCW + 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_VAL  = 3'd5;
    localparam logic [2:0] S_VAL2 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]   state_reg;
    cmd_t         cmd_reg;
    logic [VCW-1:0] vcount_reg;
    logic [FCW-1:0] frames_reg;
    logic [ECW-1:0] ecount_reg;
    logic [VCW-1:0] peak_reg;
    logic [ECW-1:0] idx_reg;
    logic [1:0]   status_reg;
    logic [VAW:0] slot_reg;
    logic         done_reg;

    // value RAM
    logic                   v_we;
    logic [VAW-1:0]         v_waddr, v_raddr;
    logic [VALUE_WIDTH-1:0] v_wdata, v_rdata;
    svs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(VALUE_DEPTH)) u_vram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    // frame RAM: {var mark, size mark}
    logic                 f_we;
    logic [FAW-1:0]       f_waddr, f_raddr;
    logic [ECW+VCW-1:0]   f_wdata, f_rdata;
    svs_ram #(.WIDTH(ECW + VCW), .DEPTH(FRAME_DEPTH)) u_fram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    // table RAM: {slot, depth, id}
    logic           e_we;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [ENW-1:0] e_wdata, e_rdata;
    svs_ram #(.WIDTH(ENW), .DEPTH(VAR_DEPTH)) u_eram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    logic [VAW-1:0] e_slot;
    logic [FCW-1:0] e_depth;
    logic [31:0]    e_id;
    assign e_slot  = e_rdata[ENW-1 -: VAW];
    assign e_depth = e_rdata[32 +: FCW];
    assign e_id    = e_rdata[31:0];

    logic vfull, vempty, efull, ffull, fempty;
    assign vfull  = (vcount_reg >= VCW'(VALUE_DEPTH));
    assign vempty = (vcount_reg == '0);
    assign efull  = (ecount_reg >= ECW'(VAR_DEPTH));
    assign ffull  = (frames_reg >= FCW'(FRAME_DEPTH));
    assign fempty = (frames_reg == '0);

    logic [VCW-1:0] top;
    assign top = vcount_reg - VCW'(1);

    logic [VALUE_WIDTH-1:0] vin_m;
    assign vin_m = cmd_reg.value_in[VALUE_WIDTH-1:0];

    logic take;
    assign take = start && !busy;

    logic [2:0]     state_next;
    logic [VCW-1:0] vcount_next, peak_next;
    logic [FCW-1:0] frames_next;
    logic [ECW-1:0] ecount_next, idx_next;
    logic [1:0]     status_next;
    logic [VAW:0]   slot_next;

    always_comb
    begin
        state_next  = state_reg;
        vcount_next = vcount_reg;
        peak_next   = peak_reg;
        frames_next = frames_reg;
        ecount_next = ecount_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        v_we = 1'b0; v_waddr = slot_reg[VAW-1:0]; v_wdata = vin_m;
        v_raddr = slot_reg[VAW-1:0];
        f_we = 1'b0; f_waddr = frames_reg[FAW-1:0];
        f_wdata = {ecount_reg, vcount_reg};
        f_raddr = FAW'(frames_reg - FCW'(1));
        e_we = 1'b0; e_waddr = ecount_reg[EAW-1:0];
        e_wdata = {vcount_reg[VAW-1:0], frames_reg, cmd_reg.var_id};
        e_raddr = EAW'(idx_reg - ECW'(1));
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // frame mark read for pop_frame is issued here by default
                status_next = ST_OK;
                slot_next   = '1;
                state_next  = S_EXEC;
                idx_next    = ecount_reg;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg.kind)
                    KIND_PUSH_FRAME:
                    begin
                        if (ffull) status_next = ST_FULL;
                        else
                        begin
                            f_we = 1'b1;
                            frames_next = frames_reg + FCW'(1);
                        end
                    end
                    KIND_POP_FRAME:
                    begin
                        if (fempty) status_next = ST_EMPTY;
                        else
                        begin
                            frames_next = frames_reg - FCW'(1);
                            vcount_next = f_rdata[VCW-1:0];
                            ecount_next = f_rdata[ECW+VCW-1 -: ECW];
                        end
                    end
                    KIND_PUSH_VALUE, KIND_PUSH_VARIABLE:
                    begin
                        if (vfull || (cmd_reg.kind == KIND_PUSH_VARIABLE && efull))
                            status_next = ST_FULL;
                        else
                        begin
                            v_we = 1'b1;
                            v_waddr = vcount_reg[VAW-1:0];
                            slot_next = {1'b0, vcount_reg[VAW-1:0]};
                            if (cmd_reg.kind == KIND_PUSH_VARIABLE)
                            begin
                                v_wdata = '0;
                                e_we = 1'b1;
                                ecount_next = ecount_reg + ECW'(1);
                            end
                            vcount_next = vcount_reg + VCW'(1);
                            if (vcount_reg + VCW'(1) > peak_reg)
                                peak_next = vcount_reg + VCW'(1);
                            state_next = S_VAL;
                        end
                    end
                    KIND_POP_VALUE, KIND_READ_TOP:
                    begin
                        if (vempty) status_next = ST_EMPTY;
                        else
                        begin
                            slot_next = {1'b0, top[VAW-1:0]};
                            state_next = S_VAL;
                        end
                    end
                    KIND_FIND, KIND_FIND_IN_SCOPE:
                    begin
                        status_next = ST_MISS;
                        state_next = S_SCAN;
                    end
                    KIND_WRITE_SLOT:
                    begin
                        if ({1'b0, cmd_reg.slot_in} >= 9'(vcount_reg) ||
                            32'(cmd_reg.slot_in) >= 32'(VALUE_DEPTH))
                            status_next = ST_MISS;
                        else
                        begin
                            v_we = 1'b1;
                            v_waddr = VAW'(cmd_reg.slot_in);
                            slot_next = {1'b0, VAW'(cmd_reg.slot_in)};
                            state_next = S_VAL;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                // read address idx-1 issued this cycle
                if (idx_reg == '0) state_next = S_DONE;
                else state_next = S_CMP;
            end
            S_CMP:
            begin
                idx_next = idx_reg - ECW'(1);
                if (cmd_reg.kind == KIND_FIND_IN_SCOPE && e_depth != frames_reg)
                    state_next = S_DONE;
                else if (e_id == cmd_reg.var_id)
                begin
                    status_next = ST_OK;
                    slot_next = {1'b0, e_slot};
                    state_next = S_VAL;
                end
                else state_next = S_SCAN;
            end
            S_VAL:
            begin
                state_next = S_VAL2;
            end
            S_VAL2:
            begin
                if (cmd_reg.kind == KIND_POP_VALUE)
                begin
                    v_we = 1'b1;
                    v_wdata = '0;
                    vcount_next = top;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [VALUE_WIDTH-1:0] val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= '0;
            frames_reg <= '0;
            ecount_reg <= '0;
            peak_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            frames_reg <= frames_next;
            ecount_reg <= ecount_next;
            peak_reg   <= peak_next;
            done_reg   <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && take)
        begin
            cmd_reg <= cmd;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        if (state_reg == S_VAL2)
        begin
            val_reg <= v_rdata;
        end
        else if (state_reg == S_EXEC)
        begin
            val_reg <= '0;
        end
    end

    // read data of a just-written slot shows the old word, so write results
    // take their value from the command
    logic [63:0] val_out;
    always_comb
    begin
        val_out = 64'(val_reg);
        if (slot_reg[VAW] || status_reg != ST_OK)
            val_out = '0;
        else if (cmd_reg.kind == KIND_PUSH_VALUE || cmd_reg.kind == KIND_WRITE_SLOT)
            val_out = 64'(vin_m);
        else if (cmd_reg.kind == KIND_PUSH_VARIABLE)
            val_out = '0;
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    always_comb
    begin
        rsp.status          = status_reg;
        rsp.slot            = (slot_reg[VAW] || status_reg != ST_OK) ? 8'd0
                              : 8'(slot_reg[VAW-1:0]);
        rsp.value_out       = val_out;
        rsp.frame_depth_out = 7'(frames_reg);
        rsp.stack_size_out  = 9'(vcount_reg);
        rsp.peak_size       = 9'(peak_reg);
    end

    assert property (@(posedge clk) disable iff (!rst_n) peak_reg >= vcount_reg)
        else $error("peak below stack size");
    assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCW'(VALUE_DEPTH)) else $error("stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= FCW'(FRAME_DEPTH)) else $error("frame overflow");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while not busy");
endmodule
